### src/count_prefixed_utf8_list_decoder_unit_defines.svh
// assertion macros for the count-prefixed utf-8 list decoder
`ifndef COUNT_PREFIXED_UTF8_LIST_DECODER_UNIT_DEFINES_SVH
`define COUNT_PREFIXED_UTF8_LIST_DECODER_UNIT_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication, sampled on clk, off during reset
`define CPUD_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cpud check failed");

// next-cycle implication, sampled on clk, off during reset
`define CPUD_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cpud check failed");

`else

`define CPUD_ASSERT_IMP(name, ante, cons)
`define CPUD_ASSERT_NEXT(name, ante, cons)

`endif

`endif

### src/cpud_pkg.sv
// shared constants and types for the count-prefixed utf-8 list decoder
`default_nettype none

package cpud_pkg;

    localparam int CountBits    = 20;
    localparam int ValBits      = 31;
    localparam int MaxCountBits = 20;
    localparam int LeftBits     = 3;

    localparam logic [MaxCountBits-1:0] MaxCountReset = MaxCountBits'(20000);
    localparam logic [ValBits:0] IdxMask = (ValBits+1)'((64'd1 << CountBits) - 64'd1);

    // lead byte class boundaries
    localparam logic [7:0] LeadAsciiTop = 8'h80;
    localparam logic [7:0] LeadTwo      = 8'hC0;
    localparam logic [7:0] LeadThree    = 8'hE0;
    localparam logic [7:0] LeadFour     = 8'hF0;
    localparam logic [7:0] LeadFive     = 8'hF8;
    localparam logic [7:0] LeadSix      = 8'hFC;
    localparam logic [7:0] LeadBad      = 8'hFE;

    typedef logic [ValBits-1:0]      val_t;
    typedef logic [CountBits-1:0]    idx_t;
    typedef logic [MaxCountBits-1:0] cnt_t;
    typedef logic [LeftBits-1:0]     left_t;

endpackage

`default_nettype wire

### src/count_prefixed_utf8_list_decoder_unit.sv
// top level of the count-prefixed utf-8 list decoder
// usage:
//   input channel: in_valid/in_ready carry one byte beat (byte_in, field_end)
//   output channel: out_valid/out_ready carry one result beat (value,
//   entry_index, last_entry, bad_lead, short_list, rejected)
//   config channel: cfg_valid/cfg_ready write max_count, always ready;
//   write only while no byte is in flight
//   the first utf-8 word of a field is the list length, each following word
//   is one entry; a zero byte or field_end closes the field
//   a taken byte beat goes through the input register, then is decoded into
//   the result register, from which its result leaves
//   throughput: one byte per cycle when the output is not stalled; the
//   decode state (accumulator, bytes left, index) updates in a loop between
//   the two registers; a byte with no result still passes the input stage
//   stall: while out_ready is low and a result waits, the input register
//   holds one more byte, then in_ready drops; nothing is lost or repeated
//   reset: max_count returns to 20000, the decoder waits for a count word,
//   both registers are emptied
`default_nettype none
`include "count_prefixed_utf8_list_decoder_unit_defines.svh"

module count_prefixed_utf8_list_decoder_unit (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // byte beats
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [7:0]                       byte_in,
    input  wire logic                             field_end,
    // result beats
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [cpud_pkg::ValBits-1:0]          value,
    output logic [cpud_pkg::CountBits-1:0]        entry_index,
    output logic                                  last_entry,
    output logic                                  bad_lead,
    output logic                                  short_list,
    output logic                                  rejected,
    // max_count write
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [cpud_pkg::MaxCountBits-1:0] max_count
);

    typedef enum logic [1:0] {
        ST_COUNT,
        ST_LIST,
        ST_DONE
    } phase_t;

    // state and registers
    phase_t               phase_reg, phase_next;
    cpud_pkg::left_t      bytes_left_reg, bytes_left_next;
    cpud_pkg::val_t       acc_reg, acc_next;
    cpud_pkg::idx_t       list_length_reg, list_length_next;
    cpud_pkg::idx_t       next_index_reg, next_index_next;
    cpud_pkg::cnt_t       max_count_reg, max_count_next;

    // input stage
    logic                 in_valid_reg, in_valid_next;
    logic [7:0]           byte_reg, byte_next;
    logic                 fe_reg, fe_next;

    // result stage
    logic                 out_valid_reg, out_valid_next;
    cpud_pkg::val_t       value_reg, value_next;
    cpud_pkg::idx_t       index_reg, index_next;
    logic                 last_reg, last_next;
    logic                 bad_reg, bad_next;
    logic                 short_reg, short_next;
    logic                 rej_reg, rej_next;

    // decode scratch
    logic                 proc_go;
    logic                 emit;
    logic                 word_done;
    logic                 bad;
    cpud_pkg::val_t       word;
    cpud_pkg::val_t       acc_shift;
    logic [cpud_pkg::CountBits:0] idx_inc;
    logic                 is_last;
    logic                 count_bad;

    // the input register drains when the result register can take a beat
    assign proc_go   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || proc_go;
    assign cfg_ready = 1'b1;

    assign acc_shift = {acc_reg[cpud_pkg::ValBits-7:0], byte_reg[5:0]};
    assign idx_inc   = {1'b0, next_index_reg} + 1'b1;
    assign is_last   = idx_inc >= {1'b0, list_length_reg};

    always_comb
    begin
        phase_next       = phase_reg;
        bytes_left_next  = bytes_left_reg;
        acc_next         = acc_reg;
        list_length_next = list_length_reg;
        next_index_next  = next_index_reg;
        max_count_next   = max_count_reg;

        in_valid_next    = in_valid_reg;
        byte_next        = byte_reg;
        fe_next          = fe_reg;

        out_valid_next   = out_valid_reg;
        value_next       = value_reg;
        index_next       = index_reg;
        last_next        = last_reg;
        bad_next         = bad_reg;
        short_next       = short_reg;
        rej_next         = rej_reg;

        emit             = 1'b0;
        word_done        = 1'b0;
        bad              = 1'b0;
        word             = '0;
        count_bad        = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            max_count_next = max_count;
        end

        // result register drains on a taken beat
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (proc_go)
        begin
            // defaults for a result carrying no entry
            value_next = '0;
            index_next = '0;
            last_next  = 1'b1;
            bad_next   = 1'b0;
            short_next = 1'b0;
            rej_next   = 1'b0;

            if (phase_reg == ST_DONE)
            begin
                // trailing bytes are dropped until the field closes
            end
            else if (byte_reg == 8'h00)
            begin
                // zero byte closes the field, partial word dropped
                if (phase_reg == ST_COUNT)
                begin
                    if (bytes_left_reg != '0)
                    begin
                        emit     = 1'b1;
                        rej_next = 1'b1;
                    end
                end
                else
                begin
                    emit       = 1'b1;
                    index_next = next_index_reg;
                    short_next = 1'b1;
                end
            end
            else
            begin
                if (bytes_left_reg == '0)
                begin
                    // lead byte
                    if (byte_reg < cpud_pkg::LeadAsciiTop)
                    begin
                        word      = cpud_pkg::ValBits'(byte_reg);
                        word_done = 1'b1;
                    end
                    else if (byte_reg < cpud_pkg::LeadTwo || byte_reg >= cpud_pkg::LeadBad)
                    begin
                        bad       = 1'b1;
                        word_done = 1'b1;
                    end
                    else if (byte_reg < cpud_pkg::LeadThree)
                    begin
                        acc_next        = cpud_pkg::ValBits'(byte_reg[4:0]);
                        bytes_left_next = cpud_pkg::LeftBits'(1);
                    end
                    else if (byte_reg < cpud_pkg::LeadFour)
                    begin
                        acc_next        = cpud_pkg::ValBits'(byte_reg[3:0]);
                        bytes_left_next = cpud_pkg::LeftBits'(2);
                    end
                    else if (byte_reg < cpud_pkg::LeadFive)
                    begin
                        acc_next        = cpud_pkg::ValBits'(byte_reg[2:0]);
                        bytes_left_next = cpud_pkg::LeftBits'(3);
                    end
                    else if (byte_reg < cpud_pkg::LeadSix)
                    begin
                        acc_next        = cpud_pkg::ValBits'(byte_reg[1:0]);
                        bytes_left_next = cpud_pkg::LeftBits'(4);
                    end
                    else
                    begin
                        acc_next        = cpud_pkg::ValBits'(byte_reg[0]);
                        bytes_left_next = cpud_pkg::LeftBits'(5);
                    end
                end
                else
                begin
                    // continuation byte, low six bits taken unchecked
                    acc_next        = acc_shift;
                    bytes_left_next = bytes_left_reg - 1'b1;
                    if (bytes_left_reg == cpud_pkg::LeftBits'(1))
                    begin
                        word      = acc_shift;
                        word_done = 1'b1;
                    end
                end

                if (word_done)
                begin
                    acc_next = '0;
                    if (phase_reg == ST_COUNT)
                    begin
                        count_bad = (word == '0)
                            || (word > {{(cpud_pkg::ValBits-cpud_pkg::MaxCountBits){1'b0}},
                                        max_count_reg})
                            || ({1'b0, word} > cpud_pkg::IdxMask);
                        if (count_bad)
                        begin
                            emit       = 1'b1;
                            bad_next   = bad;
                            rej_next   = 1'b1;
                            phase_next = ST_DONE;
                        end
                        else
                        begin
                            list_length_next = word[cpud_pkg::CountBits-1:0];
                            next_index_next  = '0;
                            phase_next       = ST_LIST;
                            if (fe_reg)
                            begin
                                emit       = 1'b1;
                                short_next = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        emit            = 1'b1;
                        value_next      = word;
                        index_next      = next_index_reg;
                        last_next       = is_last || fe_reg;
                        bad_next        = bad;
                        short_next      = !is_last && fe_reg;
                        next_index_next = idx_inc[cpud_pkg::CountBits-1:0];
                        if (is_last)
                        begin
                            phase_next = ST_DONE;
                        end
                    end
                end
                else if (fe_reg)
                begin
                    // field closed inside a word
                    emit = 1'b1;
                    if (phase_reg == ST_COUNT)
                    begin
                        rej_next = 1'b1;
                    end
                    else
                    begin
                        index_next = next_index_reg;
                        short_next = 1'b1;
                    end
                end
            end

            // end of field returns the decoder to the count phase
            if (byte_reg == 8'h00 || fe_reg)
            begin
                phase_next       = ST_COUNT;
                bytes_left_next  = '0;
                acc_next         = '0;
                list_length_next = '0;
                next_index_next  = '0;
            end

            out_valid_next = emit;
            in_valid_next  = 1'b0;
        end

        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
            byte_next     = byte_in;
            fe_next       = field_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= ST_COUNT;
            bytes_left_reg  <= '0;
            acc_reg         <= '0;
            list_length_reg <= '0;
            next_index_reg  <= '0;
            max_count_reg   <= cpud_pkg::MaxCountReset;
            in_valid_reg    <= 1'b0;
            byte_reg        <= '0;
            fe_reg          <= 1'b0;
            out_valid_reg   <= 1'b0;
            value_reg       <= '0;
            index_reg       <= '0;
            last_reg        <= 1'b0;
            bad_reg         <= 1'b0;
            short_reg       <= 1'b0;
            rej_reg         <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            bytes_left_reg  <= bytes_left_next;
            acc_reg         <= acc_next;
            list_length_reg <= list_length_next;
            next_index_reg  <= next_index_next;
            max_count_reg   <= max_count_next;
            in_valid_reg    <= in_valid_next;
            byte_reg        <= byte_next;
            fe_reg          <= fe_next;
            out_valid_reg   <= out_valid_next;
            value_reg       <= value_next;
            index_reg       <= index_next;
            last_reg        <= last_next;
            bad_reg         <= bad_next;
            short_reg       <= short_next;
            rej_reg         <= rej_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign value       = value_reg;
    assign entry_index = index_reg;
    assign last_entry  = last_reg;
    assign bad_lead    = bad_reg;
    assign short_list  = short_reg;
    assign rejected    = rej_reg;

    // checks
    `CPUD_ASSERT_IMP(a_no_entry_result, out_valid_reg && rej_reg, last_reg && value_reg == '0)
    `CPUD_ASSERT_IMP(a_flags_exclusive, out_valid_reg, !(rej_reg && short_reg))
    `CPUD_ASSERT_IMP(a_no_word_when_done, bytes_left_reg != '0, phase_reg != ST_DONE)
    `CPUD_ASSERT_IMP(a_list_in_range, phase_reg == ST_LIST,
        list_length_reg != '0 && next_index_reg < list_length_reg)
    `CPUD_ASSERT_IMP(a_left_bound, 1'b1, bytes_left_reg <= cpud_pkg::LeftBits'(5))

endmodule

`default_nettype wire
